>>> src/i64dec_pkg.sv
// Shared constants, types and the binary-to-BCD step for the 64-bit decimal text unit.
`timescale 1ns / 1ps

package i64dec_pkg;

  // Field widths
  localparam int VALUE_W    = 64;
  localparam int CHAR_W     = 6;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 8;

  // Decimal digit store: 20 BCD digits cover any 64-bit magnitude
  localparam int DIGITS     = 20;
  localparam int BCD_W      = DIGITS * 4;
  localparam int DIG_CNT_W  = $clog2(DIGITS + 1);

  // Conversion: binary bits folded into the BCD store per cycle
  localparam int STEP_BITS  = 8;
  localparam int CONV_STEPS = VALUE_W / STEP_BITS;
  localparam int STEP_CNT_W = $clog2(CONV_STEPS);

  // Leading zero digits dropped per cycle in the wide skip
  localparam int SKIP_WIDE  = 4;

  // Character codes
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CONV  = 5'b00010,
    ST_SKIP  = 5'b00100,
    ST_SIGN  = 5'b01000,
    ST_DIGIT = 5'b10000
  } state_t;

  // Shift STEP_BITS binary bits (msb first) into a BCD accumulator, add-3 style
  function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
                                                   input logic [STEP_BITS-1:0] bits);
    logic [BCD_W-1:0] acc;
    logic [3:0]       d;
    acc = bcd;
    for (int b = STEP_BITS - 1; b >= 0; b--) begin
      for (int i = 0; i < DIGITS; i++) begin
        d = acc[i*4 +: 4];
        if (d >= 4'd5) begin
          acc[i*4 +: 4] = d + 4'd3;
        end
      end
      acc = {acc[BCD_W-2:0], bits[b]};
    end
    return acc;
  endfunction

endpackage

>>> src/signed_int64_to_decimal_ascii_unit.sv
// Signed 64-bit integer to decimal ASCII character stream, top level.
`timescale 1ns / 1ps

// Converts one signed 64-bit integer per input transfer into its decimal text,
// most significant character first, one character per output transfer with
// tlast on the final one. Negative values get a leading '-'; zero gives "0".
// The input is taken only while the unit is idle. After the input transfer,
// the magnitude is folded into a 20-digit BCD register, 8 bits per cycle
// through one combinational add-3 network; then leading zero digits are
// dropped (four at a time, then one at a time) and the first character is
// picked; then characters leave one per cycle while the output is not
// stalled, and the unit returns to idle as the last one is registered.
// A registered output stage lets the next input transfer be accepted while
// the last character of the previous number still waits.

module signed_int64_to_decimal_ascii_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: [63:0] value
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [i64dec_pkg::IN_DATA_W-1:0]    in_tdata,
  // out_tdata: [5:0] character, [7:6] zero
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [i64dec_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                                out_tlast
);

  i64dec_pkg::state_t                      state_r, state_nxt;
  logic [i64dec_pkg::VALUE_W-1:0]          bin_r, bin_nxt;
  logic [i64dec_pkg::BCD_W-1:0]            bcd_r, bcd_nxt;
  logic                                    neg_r, neg_nxt;
  logic [i64dec_pkg::STEP_CNT_W-1:0]       step_r, step_nxt;
  logic [i64dec_pkg::DIG_CNT_W-1:0]        dig_r, dig_nxt;
  logic                                    out_valid_r, out_valid_nxt;
  logic [i64dec_pkg::CHAR_W-1:0]           out_char_r, out_char_nxt;
  logic                                    out_last_r, out_last_nxt;

  logic                                    in_xfer;
  logic                                    out_free;
  logic [i64dec_pkg::VALUE_W-1:0]          in_mag;
  logic [3:0]                              top_digit;
  logic                                    top_wide_zero;

  assign in_tready = (state_r == i64dec_pkg::ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Unsigned magnitude; the most negative value maps to 2^63
  assign in_mag = in_tdata[i64dec_pkg::VALUE_W-1] ?
                  (~in_tdata[i64dec_pkg::VALUE_W-1:0] + 64'd1) :
                  in_tdata[i64dec_pkg::VALUE_W-1:0];

  assign top_digit     = bcd_r[i64dec_pkg::BCD_W-1 -: 4];
  assign top_wide_zero = (bcd_r[i64dec_pkg::BCD_W-1 -: 4*i64dec_pkg::SKIP_WIDE] == '0);

  // Sequencer and datapath next state
  always_comb begin
    state_nxt     = state_r;
    bin_nxt       = bin_r;
    bcd_nxt       = bcd_r;
    neg_nxt       = neg_r;
    step_nxt      = step_r;
    dig_nxt       = dig_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    // Drop the held character once it is transferred
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      i64dec_pkg::ST_IDLE: begin
        if (in_xfer) begin
          neg_nxt   = in_tdata[i64dec_pkg::VALUE_W-1];
          bin_nxt   = in_mag;
          bcd_nxt   = '0;
          step_nxt  = '0;
          state_nxt = i64dec_pkg::ST_CONV;
        end
      end
      i64dec_pkg::ST_CONV: begin
        bcd_nxt  = i64dec_pkg::dabble_step(
                     bcd_r, bin_r[i64dec_pkg::VALUE_W-1 -: i64dec_pkg::STEP_BITS]);
        bin_nxt  = bin_r << i64dec_pkg::STEP_BITS;
        step_nxt = step_r + i64dec_pkg::STEP_CNT_W'(1);
        if (step_r == i64dec_pkg::STEP_CNT_W'(i64dec_pkg::CONV_STEPS - 1)) begin
          dig_nxt   = i64dec_pkg::DIG_CNT_W'(i64dec_pkg::DIGITS);
          state_nxt = i64dec_pkg::ST_SKIP;
        end
      end
      i64dec_pkg::ST_SKIP: begin
        if (top_wide_zero &&
            dig_r > i64dec_pkg::DIG_CNT_W'(i64dec_pkg::SKIP_WIDE)) begin
          bcd_nxt = bcd_r << (4 * i64dec_pkg::SKIP_WIDE);
          dig_nxt = dig_r - i64dec_pkg::DIG_CNT_W'(i64dec_pkg::SKIP_WIDE);
        end else if (top_digit == 4'd0 && dig_r > i64dec_pkg::DIG_CNT_W'(1)) begin
          bcd_nxt = bcd_r << 4;
          dig_nxt = dig_r - i64dec_pkg::DIG_CNT_W'(1);
        end else begin
          state_nxt = neg_r ? i64dec_pkg::ST_SIGN : i64dec_pkg::ST_DIGIT;
        end
      end
      i64dec_pkg::ST_SIGN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = i64dec_pkg::ASCII_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = i64dec_pkg::ST_DIGIT;
        end
      end
      i64dec_pkg::ST_DIGIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = i64dec_pkg::ASCII_ZERO + {2'b00, top_digit};
          out_last_nxt  = (dig_r == i64dec_pkg::DIG_CNT_W'(1));
          bcd_nxt       = bcd_r << 4;
          dig_nxt       = dig_r - i64dec_pkg::DIG_CNT_W'(1);
          if (dig_r == i64dec_pkg::DIG_CNT_W'(1)) begin
            state_nxt = i64dec_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = i64dec_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= i64dec_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    bin_r      <= bin_nxt;
    bcd_r      <= bcd_nxt;
    neg_r      <= neg_nxt;
    step_r     <= step_nxt;
    dig_r      <= dig_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(i64dec_pkg::OUT_DATA_W - i64dec_pkg::CHAR_W){1'b0}}, out_char_r};
  assign out_tlast  = out_last_r;

  // Every emitted character is a minus sign or a decimal digit
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_char_r == i64dec_pkg::ASCII_MINUS) ||
                    ((out_char_r >= i64dec_pkg::ASCII_ZERO) &&
                     (out_char_r <= i64dec_pkg::ASCII_ZERO + 6'd9)))
    else $error("output character outside '-' and '0'..'9'");

  // A minus sign never closes a number
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_char_r == i64dec_pkg::ASCII_MINUS) |-> !out_last_r)
    else $error("minus sign flagged as last character");

  // Digit count stays nonzero while zeros are skipped and digits are being sent
  a_dig_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == i64dec_pkg::ST_DIGIT || state_r == i64dec_pkg::ST_SKIP) |-> dig_r != '0)
    else $error("digit count ran out before the last character");

  // The BCD fold ends after its fixed number of steps
  a_conv_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == i64dec_pkg::ST_CONV &&
     step_r == i64dec_pkg::STEP_CNT_W'(i64dec_pkg::CONV_STEPS - 1))
    |=> state_r == i64dec_pkg::ST_SKIP)
    else $error("conversion did not hand over to zero skipping");

  // An accepted input starts the conversion
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == i64dec_pkg::ST_CONV && step_r == '0))
    else $error("input transfer did not start the conversion");

endmodule
